### design/atcg_pkg.sv
// ----------------------------------------------------------------------------
// atcg_pkg: shared types and constants of the text console grid
// Grid geometry, character and escape codes, transaction types and helpers.
// ----------------------------------------------------------------------------
package atcg_pkg;

    localparam int GRID_ROWS  = 32;
    localparam int GRID_COLS  = 64;
    localparam int PARAM_KEEP = 15;

    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ROW_W1    = ROW_W + 1;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int CURCOL_W  = $clog2(GRID_COLS + 1);
    localparam int KEEP_W    = $clog2(PARAM_KEEP + 1);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam int TAB_SPACES = 4;
    localparam int CNT_W      = $clog2(TAB_SPACES + 1);

    // Stream byte codes.
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_CUP_H    = 8'h48;
    localparam logic [7:0] CH_ED_J     = 8'h4A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_HVP_F    = 8'h66;
    localparam logic [7:0] CH_SGR_M    = 8'h6D;

    // Color codes and SGR numbers.
    localparam logic [3:0] COLOR_DEFAULT = 4'd7;
    localparam logic [3:0] COLOR_DIM     = 4'd1;
    localparam logic [3:0] COLOR_RED     = 4'd8;
    localparam logic [7:0] SGR_RESET     = 8'd0;
    localparam logic [7:0] SGR_DIM       = 8'd2;
    localparam logic [7:0] SGR_FG_BASE   = 8'd30;
    localparam logic [7:0] SGR_FG_RED    = 8'd31;
    localparam logic [7:0] SGR_FG_LAST   = 8'd37;
    localparam logic [7:0] SGR_FG_DEF    = 8'd39;
    localparam logic [7:0] NUM_MAX       = 8'd255;

    // Which cursor-position number the parser is collecting.
    localparam logic [1:0] FIELD_ROW  = 2'd0;
    localparam logic [1:0] FIELD_COL  = 2'd1;
    localparam logic [1:0] FIELD_NONE = 2'd2;

    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } atcg_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } atcg_state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cell_color;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } out_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] color;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    // Decimal digit append, saturating at 255.
    function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'h00, d};
        return (n > {4'h0, NUM_MAX}) ? NUM_MAX : n[7:0];
    endfunction

    function automatic logic [3:0] sgr_apply(input logic [3:0] col, input logic [7:0] n);
        logic [7:0] diff;
        diff = n - SGR_FG_BASE;
        if (n == SGR_RESET || n == SGR_FG_DEF) begin
            return COLOR_DEFAULT;
        end else if (n == SGR_DIM) begin
            return COLOR_DIM;
        end else if (n == SGR_FG_RED) begin
            return COLOR_RED;
        end else if (n >= SGR_FG_BASE && n <= SGR_FG_LAST) begin
            return diff[3:0];
        end
        return col;
    endfunction

    // Screen row to memory row through the circular top-of-screen pointer.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= ROW_W1'(GRID_ROWS)) begin
            sum = sum - ROW_W1'(GRID_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

endpackage

### design/atcg_ram.sv
// ----------------------------------------------------------------------------
// atcg_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module atcg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/ansi_text_console_grid_unit.sv
// ----------------------------------------------------------------------------
// ansi_text_console_grid_unit: byte-stream text console with a colored grid
// Control and escape bytes go from IDLE to DONE, a read through READ, a
// printable byte or tab through PUT; a wrap adds a PUT step, and a row blanked
// by reset, clear or scroll is first swept in SWEEP, one cell per RAM write.
// One transaction is in work at a time. Reset blanks the grid at once through
// per-row valid bits and homes the cursor; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ansi_text_console_grid_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  atcg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output atcg_pkg::out_item_t m_data
);
    import atcg_pkg::*;

    atcg_state_t state_reg, state_next;
    atcg_mode_t  mode_reg, mode_next;

    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [CURCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [3:0]          pen_reg, pen_next;
    logic [3:0]          pend_color_reg, pend_color_next;
    logic [KEEP_W-1:0]   kept_reg, kept_next;
    logic [1:0]          field_reg, field_next;
    logic [7:0]          first_val_reg, first_val_next;
    logic [7:0]          second_val_reg, second_val_next;
    logic                first_seen_reg, first_seen_next;
    logic                second_seen_reg, second_seen_next;
    logic [7:0]          sgr_val_reg, sgr_val_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [GRID_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [7:0]          put_char_reg, put_char_next;
    logic [CNT_W-1:0]    put_cnt_reg, put_cnt_next;
    logic [ROW_W-1:0]    sweep_row_reg, sweep_row_next;
    logic [COL_W-1:0]    sweep_col_reg, sweep_col_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [7:0]          res_char_reg, res_char_next;
    logic [3:0]          res_color_reg, res_color_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    cell_t             ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    cell_t             ram_rd_data;

    logic [7:0]           in_ch;
    logic [3:0]           in_digit;
    logic                 in_is_param;
    logic [ROW_W-1:0]     phys_cur;
    logic [ROW_W-1:0]     phys_rd;
    logic                 at_bottom;
    logic [ROW_W-1:0]     nl_row;
    logic [ROW_W-1:0]     nl_top;
    logic [GRID_ROWS-1:0] nl_valid;
    logic [7:0]           pos_r;
    logic [7:0]           pos_c;
    logic [7:0]           pos_r_dec;
    logic [7:0]           pos_c_dec;
    logic [ROW_W-1:0]     pos_row;
    logic [CURCOL_W-1:0]  pos_col;

    atcg_ram #(
        .WIDTH(CELL_W),
        .DEPTH(MEM_DEPTH)
    ) u_grid_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign in_ch       = s_data.data_byte;
    assign in_digit    = 4'(in_ch - CH_ZERO);
    assign in_is_param = (in_ch >= CH_ZERO && in_ch <= CH_NINE) || in_ch == CH_SEMI;
    assign phys_cur    = phys_row(cur_row_reg, top_reg);
    assign phys_rd     = phys_row(s_data.read_row, top_reg);
    assign at_bottom   = cur_row_reg == ROW_W'(GRID_ROWS - 1);

    // A scroll advances the top pointer; the old top row becomes the new
    // bottom row and is marked blank.
    always_comb begin
        nl_row   = cur_row_reg + 1'b1;
        nl_top   = top_reg;
        nl_valid = row_valid_reg;
        if (at_bottom) begin
            nl_row = cur_row_reg;
            nl_top = (top_reg == ROW_W'(GRID_ROWS - 1)) ? '0 : top_reg + 1'b1;
            nl_valid[top_reg] = 1'b0;
        end
    end

    // Cursor position numbers: one-based, missing gives zero, then clamped.
    assign pos_r     = first_seen_reg ? first_val_reg : 8'd0;
    assign pos_c     = second_seen_reg ? second_val_reg : 8'd0;
    assign pos_r_dec = (pos_r != 8'd0) ? pos_r - 8'd1 : 8'd0;
    assign pos_c_dec = (pos_c != 8'd0) ? pos_c - 8'd1 : 8'd0;
    assign pos_row   = (pos_r_dec > 8'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1)
                                                       : ROW_W'(pos_r_dec);
    assign pos_col   = (pos_c_dec > 8'(GRID_COLS - 1)) ? CURCOL_W'(GRID_COLS - 1)
                                                       : CURCOL_W'(pos_c_dec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_NORMAL;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            pen_reg         <= COLOR_DEFAULT;
            pend_color_reg  <= COLOR_DEFAULT;
            kept_reg        <= '0;
            field_reg       <= FIELD_ROW;
            first_val_reg   <= '0;
            second_val_reg  <= '0;
            first_seen_reg  <= 1'b0;
            second_seen_reg <= 1'b0;
            sgr_val_reg     <= '0;
            top_reg         <= '0;
            row_valid_reg   <= '0;
            put_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            pen_reg         <= pen_next;
            pend_color_reg  <= pend_color_next;
            kept_reg        <= kept_next;
            field_reg       <= field_next;
            first_val_reg   <= first_val_next;
            second_val_reg  <= second_val_next;
            first_seen_reg  <= first_seen_next;
            second_seen_reg <= second_seen_next;
            sgr_val_reg     <= sgr_val_next;
            top_reg         <= top_next;
            row_valid_reg   <= row_valid_next;
            put_cnt_reg     <= put_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        put_char_reg  <= put_char_next;
        sweep_row_reg <= sweep_row_next;
        sweep_col_reg <= sweep_col_next;
        rd_ok_reg     <= rd_ok_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        m_data_reg    <= m_data_next;
    end

    // Reads and writes of the grid RAM never overlap in time, since only one
    // transaction is in work, so no forwarding is needed.
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        pen_next         = pen_reg;
        pend_color_next  = pend_color_reg;
        kept_next        = kept_reg;
        field_next       = field_reg;
        first_val_next   = first_val_reg;
        second_val_next  = second_val_reg;
        first_seen_next  = first_seen_reg;
        second_seen_next = second_seen_reg;
        sgr_val_next     = sgr_val_reg;
        top_next         = top_reg;
        row_valid_next   = row_valid_reg;
        put_char_next    = put_char_reg;
        put_cnt_next     = put_cnt_reg;
        sweep_row_next   = sweep_row_reg;
        sweep_col_next   = sweep_col_reg;
        rd_ok_next       = rd_ok_reg;
        res_char_next    = res_char_reg;
        res_color_next   = res_color_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        s_ready          = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = '0;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.action == ACT_READ) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = {phys_rd, s_data.read_col};
                        rd_ok_next  = row_valid_reg[phys_rd];
                        state_next  = ST_READ;
                    end else begin
                        res_char_next  = 8'd0;
                        res_color_next = 4'd0;
                        state_next     = ST_DONE;
                        unique case (mode_reg)
                            MODE_ESC: begin
                                if (in_ch == CH_LBRACKET) begin
                                    mode_next        = MODE_CSI;
                                    kept_next        = '0;
                                    field_next       = FIELD_ROW;
                                    first_val_next   = '0;
                                    second_val_next  = '0;
                                    first_seen_next  = 1'b0;
                                    second_seen_next = 1'b0;
                                    sgr_val_next     = '0;
                                    pend_color_next  = pen_reg;
                                end else begin
                                    mode_next = MODE_NORMAL;
                                end
                            end
                            MODE_CSI: begin
                                if (in_is_param) begin
                                    if (kept_reg < KEEP_W'(PARAM_KEEP)) begin
                                        kept_next = kept_reg + 1'b1;
                                        if (in_ch == CH_SEMI) begin
                                            pend_color_next = sgr_apply(pend_color_reg,
                                                                        sgr_val_reg);
                                            sgr_val_next = '0;
                                            if (field_reg == FIELD_ROW) begin
                                                field_next = first_seen_reg ? FIELD_COL
                                                                            : FIELD_NONE;
                                            end else if (field_reg == FIELD_COL) begin
                                                field_next = FIELD_NONE;
                                            end
                                        end else begin
                                            sgr_val_next = sat_digit(sgr_val_reg, in_digit);
                                            if (field_reg == FIELD_ROW) begin
                                                first_val_next  = sat_digit(first_val_reg,
                                                                            in_digit);
                                                first_seen_next = 1'b1;
                                            end else if (field_reg == FIELD_COL) begin
                                                second_val_next  = sat_digit(second_val_reg,
                                                                             in_digit);
                                                second_seen_next = 1'b1;
                                            end
                                        end
                                    end
                                end else begin
                                    mode_next = MODE_NORMAL;
                                    priority if (in_ch == CH_CUP_H || in_ch == CH_HVP_F) begin
                                        cur_row_next = pos_row;
                                        cur_col_next = pos_col;
                                    end else if (in_ch == CH_SGR_M) begin
                                        pen_next = sgr_apply(pend_color_reg, sgr_val_reg);
                                    end else if (in_ch == CH_ED_J) begin
                                        row_valid_next = '0;
                                        top_next       = '0;
                                        cur_row_next   = '0;
                                        cur_col_next   = '0;
                                        pen_next       = COLOR_DEFAULT;
                                    end else begin
                                        mode_next = MODE_NORMAL;
                                    end
                                end
                            end
                            default: begin
                                priority if (in_ch == CH_ESC) begin
                                    mode_next = MODE_ESC;
                                end else if (in_ch == CH_LF) begin
                                    cur_col_next   = '0;
                                    cur_row_next   = nl_row;
                                    top_next       = nl_top;
                                    row_valid_next = nl_valid;
                                end else if (in_ch == CH_CR) begin
                                    cur_col_next = '0;
                                end else if (in_ch == CH_TAB) begin
                                    put_char_next = CH_SPACE;
                                    put_cnt_next  = CNT_W'(TAB_SPACES);
                                    state_next    = ST_PUT;
                                end else if (in_ch >= CH_SPACE) begin
                                    put_char_next = in_ch;
                                    put_cnt_next  = CNT_W'(1);
                                    state_next    = ST_PUT;
                                end else begin
                                    mode_next = MODE_NORMAL;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_PUT: begin
                priority if (cur_col_reg == CURCOL_W'(GRID_COLS)) begin
                    // Wrap pending: move to the next line first.
                    cur_col_next   = '0;
                    cur_row_next   = nl_row;
                    top_next       = nl_top;
                    row_valid_next = nl_valid;
                end else if (!row_valid_reg[phys_cur]) begin
                    sweep_row_next = phys_cur;
                    sweep_col_next = '0;
                    state_next     = ST_SWEEP;
                end else begin
                    ram_wr_en         = 1'b1;
                    ram_wr_addr       = {phys_cur, cur_col_reg[COL_W-1:0]};
                    ram_wr_data.ch    = put_char_reg;
                    ram_wr_data.color = pen_reg;
                    cur_col_next      = cur_col_reg + 1'b1;
                    put_cnt_next      = put_cnt_reg - 1'b1;
                    if (put_cnt_reg == CNT_W'(1)) begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SWEEP: begin
                // Blank a whole row before its first write after invalidation.
                ram_wr_en         = 1'b1;
                ram_wr_addr       = {sweep_row_reg, sweep_col_reg};
                ram_wr_data.ch    = CH_SPACE;
                ram_wr_data.color = COLOR_DEFAULT;
                sweep_col_next    = sweep_col_reg + 1'b1;
                if (sweep_col_reg == COL_W'(GRID_COLS - 1)) begin
                    row_valid_next[sweep_row_reg] = 1'b1;
                    state_next = ST_PUT;
                end
            end

            ST_READ: begin
                res_char_next  = rd_ok_reg ? ram_rd_data.ch : CH_SPACE;
                res_color_next = rd_ok_reg ? ram_rd_data.color : COLOR_DEFAULT;
                state_next     = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cell_char  = res_char_reg;
                    m_data_next.cell_color = res_color_reg;
                    m_data_next.cursor_row = cur_row_reg;
                    m_data_next.cursor_col = cur_col_reg;
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/atcg_checker.sv
// ----------------------------------------------------------------------------
// atcg_checker: port-level checks of the text console grid
// Tracks transactions in flight and checks result ranges and output hold.
// ----------------------------------------------------------------------------
module atcg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input atcg_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input atcg_pkg::out_item_t m_data
);
    import atcg_pkg::*;

    logic [1:0] inflight_reg, inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 2'd1;
        end else if (!in_acc && out_acc) begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Every result belongs to an accepted input transaction.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 2'd0)
        else $error("result without an accepted input transaction");

    // At most one transaction in work plus one result waiting.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 2'd2)
        else $error("too many transactions in flight");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cursor_col <= 7'(GRID_COLS)) && (m_data.cell_color <= COLOR_RED))
        else $error("result field out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind ansi_text_console_grid_unit atcg_checker u_atcg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/atcg_tb_pkg.sv
// ----------------------------------------------------------------------------
// atcg_tb_pkg: prediction and checking for the text console grid bench
// Holds a mirror of the console (grid, cursor, pen and escape parser) that
// works out the status each transaction should return, and compares the
// results that the block returns against them in order.
// ----------------------------------------------------------------------------
package atcg_tb_pkg;

    import atcg_pkg::*;

    class console_mirror;

        bit [7:0]    char_grid [GRID_ROWS*GRID_COLS];
        bit [3:0]    color_grid [GRID_ROWS*GRID_COLS];
        int unsigned cur_row;
        int unsigned cur_col;
        bit [3:0]    pen;
        atcg_mode_t  mode;
        int unsigned kept;
        logic [1:0]  field;
        bit [7:0]    row_num;
        bit [7:0]    col_num;
        bit          row_seen;
        bit          col_seen;
        bit [7:0]    sgr_num;
        bit [3:0]    color_acc;
        out_item_t   pending_status[$];

        int unsigned failures;
        int unsigned reads;
        int unsigned moves;
        int unsigned color_sets;
        int unsigned clears;
        int unsigned scrolls;
        int unsigned wraps;

        function new();
            blank_screen();
            mode = MODE_NORMAL;
            open_sequence();
        endfunction

        function void blank_screen();
            foreach (char_grid[i]) begin
                char_grid[i]  = CH_SPACE;
                color_grid[i] = COLOR_DEFAULT;
            end
            cur_row = 0;
            cur_col = 0;
            pen     = COLOR_DEFAULT;
        endfunction

        function void open_sequence();
            kept      = 0;
            field     = FIELD_ROW;
            row_num   = 0;
            col_num   = 0;
            row_seen  = 1'b0;
            col_seen  = 1'b0;
            sgr_num   = 0;
            color_acc = pen;
        endfunction

        // Moving past the bottom row shifts every row up and blanks the last.
        function void new_line();
            cur_col = 0;
            if (cur_row + 1 >= GRID_ROWS) begin
                scrolls++;
                for (int i = 0; i < GRID_COLS*(GRID_ROWS-1); i++) begin
                    char_grid[i]  = char_grid[i+GRID_COLS];
                    color_grid[i] = color_grid[i+GRID_COLS];
                end
                for (int i = GRID_COLS*(GRID_ROWS-1); i < GRID_ROWS*GRID_COLS; i++) begin
                    char_grid[i]  = CH_SPACE;
                    color_grid[i] = COLOR_DEFAULT;
                end
            end else begin
                cur_row++;
            end
        endfunction

        function void write_cell(bit [7:0] ch);
            int unsigned at;
            if (cur_col >= GRID_COLS) begin
                wraps++;
                new_line();
            end
            at = cur_row*GRID_COLS + cur_col;
            char_grid[at]  = ch;
            color_grid[at] = pen;
            cur_col++;
        endfunction

        function bit [7:0] add_digit(bit [7:0] v, bit [7:0] ch);
            int unsigned n;
            n = int'(v)*10 + int'(ch) - int'(CH_ZERO);
            return (n > 255) ? 8'd255 : 8'(n);
        endfunction

        function bit [3:0] sgr_color(bit [3:0] old, bit [7:0] n);
            if (n == SGR_RESET || n == SGR_FG_DEF) begin
                return COLOR_DEFAULT;
            end else if (n == SGR_DIM) begin
                return COLOR_DIM;
            end else if (n == SGR_FG_RED) begin
                return COLOR_RED;
            end else if (n >= SGR_FG_BASE && n <= SGR_FG_LAST) begin
                return 4'(n - SGR_FG_BASE);
            end
            return old;
        endfunction

        // A semicolon closes both the color field and the current position number.
        function void collect_param(bit [7:0] ch);
            if (ch == CH_SEMI) begin
                color_acc = sgr_color(color_acc, sgr_num);
                sgr_num = 0;
                if (field == FIELD_ROW) begin
                    field = row_seen ? FIELD_COL : FIELD_NONE;
                end else if (field == FIELD_COL) begin
                    field = FIELD_NONE;
                end
            end else begin
                sgr_num = add_digit(sgr_num, ch);
                if (field == FIELD_ROW) begin
                    row_num  = add_digit(row_num, ch);
                    row_seen = 1'b1;
                end else if (field == FIELD_COL) begin
                    col_num  = add_digit(col_num, ch);
                    col_seen = 1'b1;
                end
            end
        endfunction

        function void close_sequence(bit [7:0] fin);
            int unsigned r;
            int unsigned c;
            if (fin == CH_CUP_H || fin == CH_HVP_F) begin
                r = row_seen ? row_num : 0;
                c = col_seen ? col_num : 0;
                if (r > 0) r--;
                if (c > 0) c--;
                cur_row = (r > GRID_ROWS-1) ? GRID_ROWS-1 : r;
                cur_col = (c > GRID_COLS-1) ? GRID_COLS-1 : c;
                moves++;
            end else if (fin == CH_SGR_M) begin
                pen = sgr_color(color_acc, sgr_num);
                color_sets++;
            end else if (fin == CH_ED_J) begin
                blank_screen();
                clears++;
            end
        endfunction

        function void feed_byte(bit [7:0] ch);
            case (mode)
                MODE_ESC: begin
                    if (ch == CH_LBRACKET) begin
                        mode = MODE_CSI;
                        open_sequence();
                    end else begin
                        mode = MODE_NORMAL;
                    end
                end
                MODE_CSI: begin
                    if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_SEMI) begin
                        if (kept < PARAM_KEEP) begin
                            collect_param(ch);
                            kept++;
                        end
                    end else begin
                        close_sequence(ch);
                        mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (ch == CH_ESC) begin
                        mode = MODE_ESC;
                    end else if (ch == CH_LF) begin
                        new_line();
                    end else if (ch == CH_CR) begin
                        cur_col = 0;
                    end else if (ch == CH_TAB) begin
                        repeat (TAB_SPACES) write_cell(CH_SPACE);
                    end else if (ch >= CH_SPACE) begin
                        write_cell(ch);
                    end
                end
            endcase
        endfunction

        // Called for every accepted input transaction.
        function void note_input(in_item_t item);
            out_item_t   want;
            int unsigned at;
            want = '0;
            if (item.action == ACT_READ) begin
                reads++;
                at = int'(item.read_row)*GRID_COLS + int'(item.read_col);
                want.cell_char  = char_grid[at];
                want.cell_color = color_grid[at];
            end else begin
                feed_byte(item.data_byte);
            end
            want.cursor_row = 5'(cur_row);
            want.cursor_col = 7'(cur_col);
            pending_status.insert(pending_status.size(), want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                failures++;
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(out_item_t seen);
            out_item_t want;
            if (pending_status.size() == 0) begin
                $error("result transaction with nothing expected: %h", seen);
                failures++;
                return;
            end
            want = pending_status.pop_front();
            compare_field("cell_char", want.cell_char, seen.cell_char);
            compare_field("cell_color", 8'(want.cell_color), 8'(seen.cell_color));
            compare_field("cursor_row", 8'(want.cursor_row), 8'(seen.cursor_row));
            compare_field("cursor_col", 8'(want.cursor_col), 8'(seen.cursor_col));
        endfunction

    endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ansi_text_console_grid_unit
// Feeds directed and random byte streams (text, controls, cursor, color and
// clear sequences, malformed escapes) mixed with cell reads, with random
// gaps on both channels, and checks every result against a console mirror.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import atcg_pkg::*;
    import atcg_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          TAIL_CYCLES  = 200;
    localparam int          RANDOM_ITEMS = 800;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    console_mirror mirror = new();
    bit            steady;
    int unsigned   items_sent;
    int unsigned   cycles;

    ansi_text_console_grid_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** ansi_text_console_grid_unit: FAILED **");
        $finish;
    end

    // Result side: check on each accepted transaction, then pick the next ready.
    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                mirror.check_result(m_data);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic send_item(input in_item_t item);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.note_input(item);
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        in_item_t item;
        item.action    = ACT_FEED;
        item.data_byte = b;
        item.read_row  = 5'($urandom);
        item.read_col  = 6'($urandom);
        send_item(item);
    endtask

    task automatic read_cell(input int r, input int c);
        in_item_t item;
        item.action    = ACT_READ;
        item.data_byte = 8'($urandom);
        item.read_row  = 5'(r);
        item.read_col  = 6'(c);
        send_item(item);
    endtask

    task automatic csi(input string params, input logic [7:0] fin);
        feed(CH_ESC);
        feed(CH_LBRACKET);
        for (int i = 0; i < params.len(); i++) feed(params[i]);
        feed(fin);
    endtask

    task automatic text_burst();
        int len;
        len = $urandom_range(1, 24);
        repeat (len) begin
            case ($urandom_range(0, 19))
                0:       feed(CH_TAB);
                1:       feed(CH_LF);
                2:       feed(CH_CR);
                default: feed(8'($urandom_range(32, 255)));
            endcase
        end
    endtask

    // Cursor positioning, biased toward the bottom row and the right edge so
    // that wraps and scrolls come up often.
    task automatic random_move();
        string p;
        int    r;
        int    c;
        r = $urandom_range(0, 1) ? $urandom_range(28, 34) : $urandom_range(0, 40);
        c = $urandom_range(0, 1) ? $urandom_range(58, 66) : $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       p = "";
            1:       p = $sformatf(";%0d", c);
            2:       p = $sformatf("%0d", r);
            3:       p = $sformatf("%0d;", r);
            4:       p = $sformatf("%0d;%0d;%0d", r, c, $urandom_range(0, 9));
            5:       p = $sformatf("%0d;%0d", $urandom_range(100, 999),
                                   $urandom_range(100, 999));
            6:       p = $sformatf("000000%0d;%0d000000000", r, c);
            default: p = $sformatf("%0d;%0d", r, c);
        endcase
        csi(p, $urandom_range(0, 1) ? CH_CUP_H : CH_HVP_F);
    endtask

    task automatic random_color();
        string p;
        int    fields;
        p = "";
        fields = $urandom_range(1, 4);
        for (int i = 0; i < fields; i++) begin
            if (i > 0) p = {p, ";"};
            case ($urandom_range(0, 7))
                0:       p = p;
                1:       p = {p, "0"};
                2:       p = {p, "2"};
                3:       p = {p, "39"};
                4:       p = {p, "31"};
                7:       p = {p, $sformatf("%0d", $urandom_range(0, 300))};
                default: p = {p, $sformatf("%0d", $urandom_range(30, 37))};
            endcase
        end
        csi(p, CH_SGR_M);
    endtask

    task automatic odd_final();
        logic [7:0] fin;
        fin = 8'($urandom);
        if ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEMI) fin = CH_ESC;
        csi($sformatf("%0d", $urandom_range(0, 50)), fin);
    endtask

    task automatic noise();
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: feed(8'($urandom_range(0, 31)));
            1: feed(8'($urandom));
            default: begin
                b = 8'($urandom);
                if (b == CH_LBRACKET) b = CH_ESC;
                feed(CH_ESC);
                feed(b);
            end
        endcase
    endtask

    task automatic random_read();
        if ($urandom_range(0, 1)) begin
            read_cell(mirror.cur_row, $urandom_range(0, GRID_COLS-1));
        end else begin
            read_cell($urandom_range(0, GRID_ROWS-1), $urandom_range(0, GRID_COLS-1));
        end
    endtask

    initial begin
        int unsigned start;
        int          pick;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every byte class and the odd sequences.
        read_cell(GRID_ROWS-1, GRID_COLS-1);
        feed(CH_SPACE);
        feed(8'hFF);
        read_cell(0, 1);
        feed(CH_TAB);
        feed(CH_CR);
        feed(CH_LF);
        feed(8'h00);
        feed(CH_ESC);
        feed("Z");
        csi(";", CH_CUP_H);
        csi("999", CH_HVP_F);
        csi("31", CH_SGR_M);
        feed(8'h7E);
        csi("", CH_ED_J);
        csi("5", CH_ESC);

        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            steady = (items_sent >= start + 300) && (items_sent < start + 450);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                random_read();
            end else if (pick < 55) begin
                text_burst();
            end else if (pick < 70) begin
                random_move();
            end else if (pick < 85) begin
                random_color();
            end else if (pick < 88) begin
                csi("", CH_ED_J);
            end else if (pick < 93) begin
                odd_final();
            end else begin
                noise();
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (mirror.pending_status.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions (%0d cell reads) with %0d cursor moves, %0d pen changes and %0d clears.",
                 items_sent, mirror.reads, mirror.moves, mirror.color_sets, mirror.clears);
        $display("The cursor wrapped %0d times and the grid scrolled %0d times.",
                 mirror.wraps, mirror.scrolls);
        if (mirror.failures == 0) begin
            $display("** ansi_text_console_grid_unit: PASSED **");
        end else begin
            $display("** ansi_text_console_grid_unit: FAILED **");
        end
        $finish;
    end

endmodule
